// ----- design/ft8_free_text_decoder_macros.svh -----
// assertion macros for the ft8 free-text decoder
`ifndef FT8_FREE_TEXT_DECODER_MACROS_SVH
`define FT8_FREE_TEXT_DECODER_MACROS_SVH

// same-cycle implication, disabled during reset
`define FTD_ASSERT_NOW(lbl, clk, rstn, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |-> (cons)) \
    else $error("ftd assertion failed");

// next-cycle implication, disabled during reset
`define FTD_ASSERT_NEXT(lbl, clk, rstn, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |=> (cons)) \
    else $error("ftd assertion failed");

`endif

// ----- design/ftd_pkg.sv -----
// types, constants and the symbol table of the ft8 free-text decoder
`default_nettype none

package ftd_pkg;

  localparam int HIGH_W = 7;
  localparam int LOW_W = 64;
  localparam int CHAR_W = 7;
  localparam int POS_W = 4;
  localparam int DIGIT_W = 6;
  localparam int REM_W = 7;
  localparam int STEP_BITS = 8;
  localparam int STEPS_PER_DIGIT = 9;
  localparam int WORK_W = STEP_BITS * STEPS_PER_DIGIT;
  localparam int STEP_CNT_W = 4;

  typedef logic [HIGH_W-1:0] high_t;
  typedef logic [LOW_W-1:0] low_t;
  typedef logic [CHAR_W-1:0] char_t;
  typedef logic [POS_W-1:0] pos_t;
  typedef logic [DIGIT_W-1:0] digit_t;
  typedef logic [REM_W-1:0] rem_t;
  typedef logic [WORK_W-1:0] work_t;
  typedef logic [STEP_BITS-1:0] qbyte_t;
  typedef logic [STEP_CNT_W-1:0] step_cnt_t;

  localparam rem_t RADIX = 7'd42;
  localparam step_cnt_t LAST_STEP = 4'(STEPS_PER_DIGIT - 1);

  localparam char_t ASCII_SPACE = 7'd32;
  localparam char_t ASCII_ZERO = 7'd48;
  localparam char_t ASCII_A = 7'd65;
  localparam char_t ASCII_PLUS = 7'd43;
  localparam char_t ASCII_MINUS = 7'd45;
  localparam char_t ASCII_DOT = 7'd46;
  localparam char_t ASCII_SLASH = 7'd47;
  localparam char_t ASCII_QMARK = 7'd63;

  localparam digit_t DIG_FIRST_NUM = 6'd1;
  localparam digit_t DIG_LAST_NUM = 6'd10;
  localparam digit_t DIG_FIRST_LET = 6'd11;
  localparam digit_t DIG_LAST_LET = 6'd36;
  localparam digit_t DIG_PLUS = 6'd37;
  localparam digit_t DIG_MINUS = 6'd38;
  localparam digit_t DIG_DOT = 6'd39;
  localparam digit_t DIG_SLASH = 6'd40;
  localparam digit_t DIG_QMARK = 6'd41;

  // controller to datapath commands
  typedef struct packed {
    logic load;
    logic step;
    logic store;
    logic emit;
    pos_t idx;
  } cmd_t;

  function automatic char_t symbol_of(input digit_t d);
    char_t c;
    c = ASCII_SPACE;
    priority if (d >= DIG_FIRST_NUM && d <= DIG_LAST_NUM) begin
      c = ASCII_ZERO + char_t'(d - DIG_FIRST_NUM);
    end else if (d >= DIG_FIRST_LET && d <= DIG_LAST_LET) begin
      c = ASCII_A + char_t'(d - DIG_FIRST_LET);
    end else if (d == DIG_PLUS) begin
      c = ASCII_PLUS;
    end else if (d == DIG_MINUS) begin
      c = ASCII_MINUS;
    end else if (d == DIG_DOT) begin
      c = ASCII_DOT;
    end else if (d == DIG_SLASH) begin
      c = ASCII_SLASH;
    end else if (d == DIG_QMARK) begin
      c = ASCII_QMARK;
    end else begin
      c = ASCII_SPACE;
    end
    return c;
  endfunction

endpackage

`default_nettype wire

// ----- design/ftd_if.sv -----
// payload channel interfaces of the ft8 free-text decoder
`default_nettype none

interface ftd_in_if;
  logic valid;
  logic ready;
  ftd_pkg::high_t text_high;
  ftd_pkg::low_t text_low;

  modport source (output valid, output text_high, output text_low, input ready);
  modport sink (input valid, input text_high, input text_low, output ready);
endinterface

interface ftd_out_if;
  logic valid;
  logic ready;
  ftd_pkg::char_t char_code;
  ftd_pkg::pos_t char_position;
  logic outside_text;
  logic last_char;

  modport source (output valid, output char_code, output char_position,
                  output outside_text, output last_char, input ready);
  modport sink (input valid, input char_code, input char_position,
                input outside_text, input last_char, output ready);
endinterface

`default_nettype wire

// ----- design/ftd_datapath.sv -----
// datapath: divide-by-42 shift unit, digit store, trim tracking, output register
`default_nettype none

module ftd_datapath #(
  parameter int NUM_CHARS = 13,
  parameter int IDX_W = 4
) (
  input  wire logic            clk_i,
  input  wire ftd_pkg::cmd_t   cmd_i,
  input  wire ftd_pkg::high_t  text_high_i,
  input  wire ftd_pkg::low_t   text_low_i,
  output ftd_pkg::char_t       char_code_o,
  output ftd_pkg::pos_t        char_position_o,
  output logic                 outside_text_o,
  output logic                 last_char_o
);

  localparam logic [IDX_W-1:0] LastIdx = IDX_W'(NUM_CHARS - 1);

  ftd_pkg::work_t  work_q, work_d;
  ftd_pkg::rem_t   rem_q, rem_d;
  ftd_pkg::qbyte_t qbyte;
  ftd_pkg::digit_t digit_store [NUM_CHARS];
  logic            any_nz_q;
  logic [IDX_W-1:0] first_q, last_q;
  logic [IDX_W-1:0] idx;
  ftd_pkg::char_t  char_code_q;
  ftd_pkg::pos_t   char_position_q;
  logic            outside_q, last_char_q;

  assign idx = cmd_i.idx[IDX_W-1:0];

  // eight restoring steps on the top byte of the work word
  always_comb begin
    ftd_pkg::rem_t r;
    r = rem_q;
    qbyte = '0;
    for (int k = ftd_pkg::STEP_BITS - 1; k >= 0; k--) begin
      r = {r[ftd_pkg::REM_W-2:0], work_q[ftd_pkg::WORK_W - ftd_pkg::STEP_BITS + k]};
      if (r >= ftd_pkg::RADIX) begin
        r = r - ftd_pkg::RADIX;
        qbyte[k] = 1'b1;
      end
    end
    rem_d = r;
    work_d = {work_q[ftd_pkg::WORK_W-ftd_pkg::STEP_BITS-1:0], qbyte};
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      work_q <= {1'b0, text_high_i, text_low_i};
      rem_q <= '0;
      any_nz_q <= 1'b0;
    end else if (cmd_i.step) begin
      work_q <= work_d;
      rem_q <= cmd_i.store ? '0 : rem_d;
      if (cmd_i.store) begin
        digit_store[idx] <= rem_d[ftd_pkg::DIGIT_W-1:0];
        // digits arrive rightmost first
        if (rem_d != '0) begin
          first_q <= idx;
          if (!any_nz_q) begin
            last_q <= idx;
          end
          any_nz_q <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.emit) begin
      char_code_q <= ftd_pkg::symbol_of(digit_store[idx]);
      char_position_q <= cmd_i.idx;
      outside_q <= !any_nz_q || (idx < first_q) || (idx > last_q);
      last_char_q <= (idx == LastIdx);
    end
  end

  assign char_code_o = char_code_q;
  assign char_position_o = char_position_q;
  assign outside_text_o = outside_q;
  assign last_char_o = last_char_q;

endmodule

`default_nettype wire

// ----- design/ftd_controller.sv -----
// controller: sequences load, digit extraction and character output
`default_nettype none

module ftd_controller #(
  parameter int NUM_CHARS = 13
) (
  input  wire logic          clk_i,
  input  wire logic          rst_ni,
  input  wire logic          in_valid_i,
  output logic               in_ready_o,
  output logic               out_valid_o,
  input  wire logic          out_ready_i,
  output ftd_pkg::cmd_t      cmd_o
);

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_DIVIDE,
    ST_EMIT
  } state_e;

  localparam ftd_pkg::pos_t LastPos = ftd_pkg::pos_t'(NUM_CHARS - 1);

  state_e              state_q;
  ftd_pkg::step_cnt_t  step_q;
  ftd_pkg::pos_t       idx_q;
  logic                out_valid_q;
  logic                emit;
  logic                in_xact;

  assign in_ready_o = (state_q == ST_IDLE);
  assign in_xact = in_valid_i && in_ready_o;
  assign emit = (state_q == ST_EMIT) && (!out_valid_q || out_ready_i);
  assign out_valid_o = out_valid_q;

  always_comb begin
    cmd_o = '0;
    cmd_o.load = in_xact;
    cmd_o.step = (state_q == ST_DIVIDE);
    cmd_o.store = (state_q == ST_DIVIDE) && (step_q == ftd_pkg::LAST_STEP);
    cmd_o.emit = emit;
    cmd_o.idx = idx_q;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
      step_q <= '0;
      idx_q <= '0;
      out_valid_q <= 1'b0;
    end else begin
      if (emit) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
      unique case (state_q)
        ST_IDLE: begin
          if (in_xact) begin
            state_q <= ST_DIVIDE;
            step_q <= '0;
            idx_q <= LastPos;
          end
        end
        ST_DIVIDE: begin
          if (step_q == ftd_pkg::LAST_STEP) begin
            step_q <= '0;
            if (idx_q == '0) begin
              state_q <= ST_EMIT;
            end else begin
              idx_q <= idx_q - 1'b1;
            end
          end else begin
            step_q <= step_q + 1'b1;
          end
        end
        ST_EMIT: begin
          if (emit) begin
            if (idx_q == LastPos) begin
              state_q <= ST_IDLE;
              idx_q <= '0;
            end else begin
              idx_q <= idx_q + 1'b1;
            end
          end
        end
        default: begin
          state_q <= ST_IDLE;
        end
      endcase
    end
  end

endmodule

`default_nettype wire

// ----- design/ft8_free_text_decoder.sv -----
// top level of the ft8 free-text decoder
//
//   channel  dir  payload                                       transaction
//   in_i     in   text_high[6:0], text_low[63:0]                valid && ready
//   out_o    out  char_code, char_position, outside_text,        valid && ready
//                 last_char
//
// each character of a payload is one full division in the divide-by-42 shift unit
// (8 quotient bits a cycle over a 72-bit word); the characters then go into the
// output register one per cycle while the output does not stall. output stalls
// hold the sequencer in the emit phase; a new payload is taken once the last
// character is registered.
// reset is asynchronous, active low, and clears the controller only.
`default_nettype none
`include "ft8_free_text_decoder_macros.svh"

module ft8_free_text_decoder #(
  parameter int NUM_CHARS = 13
) (
  input  wire logic     clk_i,
  input  wire logic     rst_ni,
  ftd_in_if.sink        in_i,
  ftd_out_if.source     out_o
);

  localparam int IdxW = (NUM_CHARS > 1) ? $clog2(NUM_CHARS) : 1;
  localparam ftd_pkg::pos_t LastPos = ftd_pkg::pos_t'(NUM_CHARS - 1);

  ftd_pkg::cmd_t cmd;

  ftd_controller #(
    .NUM_CHARS (NUM_CHARS)
  ) u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_i.valid),
    .in_ready_o  (in_i.ready),
    .out_valid_o (out_o.valid),
    .out_ready_i (out_o.ready),
    .cmd_o       (cmd)
  );

  ftd_datapath #(
    .NUM_CHARS (NUM_CHARS),
    .IDX_W     (IdxW)
  ) u_dp (
    .clk_i           (clk_i),
    .cmd_i           (cmd),
    .text_high_i     (in_i.text_high),
    .text_low_i      (in_i.text_low),
    .char_code_o     (out_o.char_code),
    .char_position_o (out_o.char_position),
    .outside_text_o  (out_o.outside_text),
    .last_char_o     (out_o.last_char)
  );

  `FTD_ASSERT_NEXT(a_busy_after_load, clk_i, rst_ni, in_i.valid && in_i.ready, !in_i.ready)
  `FTD_ASSERT_NOW(a_idle_only_last_pending, clk_i, rst_ni,
                  in_i.ready && out_o.valid, out_o.last_char)
  `FTD_ASSERT_NOW(a_last_matches_pos, clk_i, rst_ni, out_o.valid,
                  out_o.last_char == (out_o.char_position == LastPos))
  `FTD_ASSERT_NOW(a_no_step_while_emit, clk_i, rst_ni, cmd.emit, !cmd.step && !cmd.load)

endmodule

`default_nettype wire
